// ----- src/dffn_pkg.sv -----
// Shared types and constants for the dF/F pixel normalizer.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package dffn_pkg;

   localparam int PIXELS     = 262144;
   localparam int PIX_W      = $clog2(PIXELS);
   localparam int HIST_BINS  = 256;
   localparam int HIST_W     = $clog2(HIST_BINS);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;
   localparam int QUO_W      = 32;
   localparam int CNT_W      = $clog2(QUO_W + 1);

   localparam logic [CSR_IDX_W-1:0] REG_BIT_DEPTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET    = 2'd2;

   localparam logic [4:0] DEPTH_MIN = 5'd8;
   localparam logic [4:0] DEPTH_MAX = 5'd16;
   localparam logic [4:0] DEPTH_RST = 5'd8;
   localparam logic [31:0] GAIN_RST  = 32'h0001_0000;
   localparam logic [QUO_W-1:0] RATIO_MAX = 32'h8000_0000;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_DIVR,
      ST_MUL,
      ST_SUM,
      ST_RND,
      ST_BLOAD,
      ST_DIVB,
      ST_HREAD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             load;
      logic             div_step;
      logic             mul_en;
      logic             sum_en;
      logic             rnd_en;
      logic             bin_load;
      logic             finish;
      logic             sweep_we;
      logic [PIX_W-1:0] sweep_addr;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ----- src/dffn_ctrl.sv -----
// Sequencer for the dF/F normalizer: clearing pass, divide steps, arithmetic
// stages and store update. Depends on dffn_pkg.
`timescale 1ns / 1ps
module dffn_ctrl
   import dffn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PIX_W-1:0] sweep_ff, sweep_in;

   // State, step count and sweep address registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         cnt_ff   <= '0;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sweep_ff <= sweep_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      sweep_in       = sweep_ff;
      cmd            = '0;
      cmd.sweep_addr = sweep_ff;
      req_stall      = 1'b1;
      case (state_ff)
         ST_SWEEP: begin
            cmd.sweep_we = 1'b1;
            sweep_in     = sweep_ff + 1'b1;
            if (sweep_ff == PIX_W'(PIXELS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = CNT_W'(QUO_W);
               state_in = ST_DIVR;
            end
         end
         ST_DIVR: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_RND;
         end
         ST_RND: begin
            cmd.rnd_en = 1'b1;
            state_in   = ST_BLOAD;
         end
         ST_BLOAD: begin
            cmd.bin_load = 1'b1;
            cnt_in       = CNT_W'(HIST_W);
            state_in     = ST_DIVB;
         end
         ST_DIVB: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_HREAD;
            end
         end
         ST_HREAD: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/dffn_datapath.sv -----
// Datapath of the dF/F normalizer: config registers, shared restoring
// divider, multiply/offset/round, pixel and histogram stores, output register.
// Depends on dffn_pkg.
`timescale 1ns / 1ps
module dffn_datapath
   import dffn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [15:0]           req_raw_value,
   input  logic [23:0]           req_mean_value,
   input  logic [PIX_W-1:0]      req_pixel_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_dff_value,
   output logic [15:0]           rsp_pixel_min,
   output logic [15:0]           rsp_pixel_max,
   output logic [31:0]           rsp_bin_count,
   output logic                  rsp_mean_zero
);

   logic [4:0]  bit_depth_ff;
   logic [31:0] gain_ff;
   logic [47:0] offset_ff;

   logic [PIX_W-1:0] idx_ff;
   logic             zero_ff, neg_ff, sat_ff;
   logic [23:0]      rem_ff, rem_in, div_ff;
   logic [QUO_W-1:0] q_ff, q_in;
   logic [24:0]      r2;
   logic             ge;
   logic [63:0]      prod_ff;
   logic [65:0]      sum_ff;
   logic [15:0]      value_ff;

   logic [24:0] num;
   logic [23:0] mag;
   logic [QUO_W-1:0] qmag;
   logic [65:0] sprod, off_ext;
   logic [33:0] ip;
   logic [34:0] ipr;
   logic        inc;
   logic [4:0]  depth;
   logic [16:0] top, bin_div;

   logic [31:0] pix_mem [PIXELS];
   logic [31:0] hist_mem [HIST_BINS];
   logic [31:0] pix_rd_ff, hist_rd_ff;
   logic        pix_we, hist_we;
   logic [PIX_W-1:0]  pix_wa;
   logic [HIST_W-1:0] hist_wa, bin;
   logic [31:0] pix_wd, hist_wd;
   logic [15:0] old_min, old_max, new_min, new_max;
   logic        in_range;

   logic        rsp_valid_ff;
   logic [15:0] rsp_dff_ff, rsp_min_ff, rsp_max_ff;
   logic [31:0] rsp_cnt_ff;
   logic        rsp_zero_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_depth_ff <= DEPTH_RST;
         gain_ff      <= GAIN_RST;
         offset_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_BIT_DEPTH: bit_depth_ff <= csr_data[4:0];
            REG_GAIN:      gain_ff      <= csr_data[31:0];
            REG_OFFSET:    offset_ff    <= csr_data[47:0];
            default:       ;
         endcase
      end
   end

   // Clamp depth and derive the saturation top and histogram divisor
   always_comb begin
      if (bit_depth_ff < DEPTH_MIN) begin
         depth = DEPTH_MIN;
      end else if (bit_depth_ff > DEPTH_MAX) begin
         depth = DEPTH_MAX;
      end else begin
         depth = bit_depth_ff;
      end
      top     = (17'd1 << depth) - 17'd1;
      bin_div = (17'd1 << depth) + 17'd1;
   end

   // Numerator magnitude (Q.8) of raw - mean
   assign num = {1'b0, req_raw_value, 8'b0} - {1'b0, req_mean_value};
   assign mag = num[24] ? 24'(-num) : num[23:0];

   // One restoring divide step
   assign r2     = {rem_ff, q_ff[QUO_W-1]};
   assign ge     = r2 >= {1'b0, div_ff};
   assign rem_in = ge ? 24'(r2 - {1'b0, div_ff}) : r2[23:0];
   assign q_in   = {q_ff[QUO_W-2:0], ge};

   // Shared divider and request latches
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff  <= req_pixel_index;
         zero_ff <= (req_mean_value == 24'd0);
         neg_ff  <= num[24];
         sat_ff  <= ({16'b0, mag[23:16]} >= req_mean_value);
         rem_ff  <= {16'b0, mag[23:16]};
         q_ff    <= {mag[15:0], 16'b0};
         div_ff  <= req_mean_value;
      end else if (cmd.bin_load) begin
         rem_ff <= {8'b0, value_ff};
         q_ff   <= '0;
         div_ff <= {7'b0, bin_div};
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   // Saturate the ratio magnitude and scale by gain
   assign qmag = (sat_ff || q_ff > RATIO_MAX) ? RATIO_MAX : q_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= gain_ff * qmag;
      end
   end

   // Apply sign and add offset aligned to Q.32
   assign sprod   = neg_ff ? 66'(66'd0 - {2'b0, prod_ff}) : {2'b0, prod_ff};
   assign off_ext = {{2{offset_ff[47]}}, offset_ff, 16'b0};

   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         sum_ff <= sprod + off_ext;
      end
   end

   // Round half to even and clamp to 0..top
   assign ip  = sum_ff[65:32];
   assign inc = sum_ff[31] && ((sum_ff[30:0] != 31'd0) || ip[0]);
   assign ipr = {ip[33], ip} + {34'b0, inc};

   always_ff @(posedge clock) begin
      if (cmd.rnd_en) begin
         if (zero_ff || ipr[34]) begin
            value_ff <= '0;
         end else if ($signed(ipr) > $signed({18'b0, top})) begin
            value_ff <= top[15:0];
         end else begin
            value_ff <= ipr[15:0];
         end
      end
   end

   // Store update values
   assign bin      = q_ff[HIST_W-1:0];
   assign in_range = ({1'b0, idx_ff} < (PIX_W + 1)'(PIXELS));
   assign old_min  = pix_rd_ff[31:16];
   assign old_max  = pix_rd_ff[15:0];
   assign new_min  = (value_ff < old_min) ? value_ff : old_min;
   assign new_max  = (value_ff > old_max) ? value_ff : old_max;

   always_comb begin
      pix_we  = cmd.sweep_we || (cmd.finish && in_range);
      pix_wa  = cmd.sweep_we ? cmd.sweep_addr : idx_ff;
      pix_wd  = cmd.sweep_we ? {16'hFFFF, 16'h0000} : {new_min, new_max};
      hist_we = cmd.sweep_we || cmd.finish;
      hist_wa = cmd.sweep_we ? cmd.sweep_addr[HIST_W-1:0] : bin;
      if (cmd.sweep_we) begin
         hist_wd = '0;
      end else if (hist_rd_ff == 32'hFFFF_FFFF) begin
         hist_wd = hist_rd_ff;
      end else begin
         hist_wd = hist_rd_ff + 32'd1;
      end
   end

   // Pixel min/max store
   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem[pix_wa] <= pix_wd;
      end
      pix_rd_ff <= pix_mem[idx_ff];
   end

   // Histogram store
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
      hist_rd_ff <= hist_mem[bin];
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_dff_ff  <= value_ff;
         rsp_min_ff  <= in_range ? new_min : value_ff;
         rsp_max_ff  <= in_range ? new_max : value_ff;
         rsp_cnt_ff  <= hist_wd;
         rsp_zero_ff <= zero_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dff_value   = rsp_dff_ff;
   assign rsp_pixel_min   = rsp_min_ff;
   assign rsp_pixel_max   = rsp_max_ff;
   assign rsp_bin_count   = rsp_cnt_ff;
   assign rsp_mean_zero   = rsp_zero_ff;

endmodule

// ----- src/dff_pixel_normalizer_with_projections_unit.sv -----
// Top level of the dF/F pixel normalizer with per-pixel min/max and histogram.
// Instantiates dffn_ctrl and dffn_datapath; depends on dffn_pkg.
`timescale 1ns / 1ps
// One request at a time: from acceptance until its result is loaded into the output
// register, a request first takes the 32 steps of the one-bit-per-cycle divider for
// the ratio. The multiply, offset, round and bin-load stages follow. The same unit
// then takes 8 more steps for the histogram bin. A histogram read and the store
// update follow. The next request is taken in the cycle after the store update.
// The output register lets the next request be taken while a result still waits.
// A stalled response adds cycles only if it is still waiting when the next result
// is ready. After reset a clearing pass over all 262144 pixel addresses initializes
// the pixel min/max store and the histogram, and req_stall stays high during it.
// Register writes are taken at any time (csr_ready is high). Write them only while
// no request is in flight.
module dff_pixel_normalizer_with_projections_unit
   import dffn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [15:0]           req_raw_value,
   input  logic [23:0]           req_mean_value,
   input  logic [PIX_W-1:0]      req_pixel_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_dff_value,
   output logic [15:0]           rsp_pixel_min,
   output logic [15:0]           rsp_pixel_max,
   output logic [31:0]           rsp_bin_count,
   output logic                  rsp_mean_zero
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   dffn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dffn_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_raw_value   (req_raw_value),
      .req_mean_value  (req_mean_value),
      .req_pixel_index (req_pixel_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_dff_value   (rsp_dff_value),
      .rsp_pixel_min   (rsp_pixel_min),
      .rsp_pixel_max   (rsp_pixel_max),
      .rsp_bin_count   (rsp_bin_count),
      .rsp_mean_zero   (rsp_mean_zero)
   );

endmodule

// ----- dv/tb_top.sv -----
// Testbench for the dF/F pixel normalizer: drives requests, register writes,
// and checks each response against an in-bench predictor. Depends on dffn_pkg.
`timescale 1ns / 1ps
module tb_top;
   import dffn_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [15:0] dff_value;
      logic [15:0] pixel_min;
      logic [15:0] pixel_max;
      logic [31:0] bin_count;
      logic        mean_zero;
   } dff_result_type;

   // Predicts normalizer responses and holds the ones still owed
   class dff_scoreboard;
      logic [4:0]  depth_reg;
      logic [31:0] gain_reg;
      logic signed [47:0] offset_reg;
      logic [15:0] min_mem [int];
      logic [15:0] max_mem [int];
      logic [31:0] hist_mem [HIST_BINS];
      dff_result_type pending_q [$];
      int errors;

      function new();
         depth_reg = DEPTH_RST;
         gain_reg = GAIN_RST;
         offset_reg = '0;
         foreach (hist_mem[i]) hist_mem[i] = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == REG_BIT_DEPTH) depth_reg = data[4:0];
         else if (idx == REG_GAIN) gain_reg = data[31:0];
         else if (idx == REG_OFFSET) offset_reg = data[47:0];
      endfunction

      // Compute the expected response and update pixel and histogram state
      function void note_request(logic [15:0] raw, logic [23:0] mean, logic [17:0] pix);
         int unsigned dep;
         longint signed top, num, ratio, ip, h;
         logic [63:0] mag, q, frac;
         logic signed [95:0] prod;
         logic [15:0] v, lo, hi;
         longint unsigned bin;
         dff_result_type r;
         dep = depth_reg < 8 ? 8 : (depth_reg > 16 ? 16 : depth_reg);
         top = (64'd1 << dep) - 1;
         ip = 0;
         r.mean_zero = (mean == 0);
         if (mean != 0) begin
            num = longint'(raw) * 256 - longint'(mean);
            mag = (num < 0 ? -num : num);
            mag = mag << 16;
            q = mag / mean;
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            ratio = num < 0 ? -longint'(q) : longint'(q);
            prod = $signed({1'b0, gain_reg}) * ratio;
            h = longint'(prod >>> 16) + longint'(offset_reg);
            ip = h >>> 16;
            frac = {32'd0, h[15:0], prod[15:0]};
            if (frac > 64'h8000_0000 || (frac == 64'h8000_0000 && ip[0])) ip++;
            if (ip < 0) ip = 0;
            if (ip > top) ip = top;
         end
         v = ip[15:0];
         if (pix < PIXELS) begin
            if (!min_mem.exists(pix)) begin
               min_mem[pix] = 16'hFFFF;
               max_mem[pix] = 16'h0;
            end
            if (v < min_mem[pix]) min_mem[pix] = v;
            if (v > max_mem[pix]) max_mem[pix] = v;
            lo = min_mem[pix];
            hi = max_mem[pix];
         end else begin
            lo = v;
            hi = v;
         end
         bin = (longint'(v) * HIST_BINS) / ((64'd1 << dep) + 1);
         if (bin >= HIST_BINS) bin = HIST_BINS - 1;
         if (hist_mem[bin] != 32'hFFFF_FFFF) hist_mem[bin]++;
         r.dff_value = v;
         r.pixel_min = lo;
         r.pixel_max = hi;
         r.bin_count = hist_mem[bin];
         pending_q = {pending_q, r};
      endfunction

      function void check_response(dff_result_type got);
         dff_result_type exp_r;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
            return;
         end
         exp_r = pending_q.pop_front();
         if (got.dff_value !== exp_r.dff_value)
            $display("%0t: dff_value exp %0d got %0d", $time, exp_r.dff_value, got.dff_value);
         if (got.pixel_min !== exp_r.pixel_min)
            $display("%0t: pixel_min exp %0d got %0d", $time, exp_r.pixel_min, got.pixel_min);
         if (got.pixel_max !== exp_r.pixel_max)
            $display("%0t: pixel_max exp %0d got %0d", $time, exp_r.pixel_max, got.pixel_max);
         if (got.bin_count !== exp_r.bin_count)
            $display("%0t: bin_count exp %0d got %0d", $time, exp_r.bin_count, got.bin_count);
         if (got.mean_zero !== exp_r.mean_zero)
            $display("%0t: mean_zero exp %0d got %0d", $time, exp_r.mean_zero, got.mean_zero);
         if (got !== exp_r) errors++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [15:0] req_raw_value = '0;
   logic [23:0] req_mean_value = '0;
   logic [PIX_W-1:0] req_pixel_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_dff_value, rsp_pixel_min, rsp_pixel_max;
   logic [31:0] rsp_bin_count;
   logic rsp_mean_zero;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   dff_scoreboard sb = new();

   dff_pixel_normalizer_with_projections_unit dut (.*);

   always #10 clock = ~clock;

   // Check accepted responses and drive the next stall value
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response({rsp_dff_value, rsp_pixel_min, rsp_pixel_max,
                            rsp_bin_count, rsp_mean_zero});
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Write one register, then drop valid
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Send one request, with a random idle gap before it
   task automatic send_request(logic [15:0] raw, logic [23:0] mean, logic [17:0] pix);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_raw_value <= raw;
      req_mean_value <= mean;
      req_pixel_index <= pix;
      do @(posedge clock); while (req_stall);
      sb.note_request(raw, mean, pix);
   endtask

   // Hold off until every owed response has arrived, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic random_phase(int n);
      logic [15:0] raw;
      logic [23:0] mean;
      logic [17:0] pix;
      for (int i = 0; i < n; i++) begin
         raw = 16'($urandom);
         pix = ($urandom_range(3) == 0) ? 18'($urandom) : 18'($urandom_range(15));
         case ($urandom_range(9))
            0: mean = '0;
            1: mean = 24'($urandom);
            2: mean = 24'($urandom_range(255));
            default: mean = (24'(raw) << 8) + 24'($urandom_range(8191)) - 24'd4096;
         endcase
         if (pix >= PIXELS) pix = pix; // all 18-bit indices are within the store
         send_request(raw, mean, pix);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // directed: field extremes, zero mean, saturation, depth clamp
      send_request(16'd0, 24'd0, 18'd0);
      send_request(16'hFFFF, 24'd1, 18'h3FFFF);
      send_request(16'd0, 24'hFFFFFF, 18'd0);
      send_request(16'hFFFF, 24'hFFFFFF, 18'h3FFFF);
      send_request(16'd100, 24'd25600, 18'd1);
      send_request(16'd101, 24'd25600, 18'd1);
      send_request(16'd1, 24'd512, 18'd2);
      drain();
      write_csr(REG_BIT_DEPTH, 48'd16);
      write_csr(REG_GAIN, 48'hFFFF_FFFF);
      write_csr(REG_OFFSET, 48'h7FFF_FFFF_FFFF);
      send_request(16'd200, 24'd51200, 18'd3);
      send_request(16'd0, 24'd256, 18'd3);
      send_request(16'hFFFF, 24'd1, 18'd3);
      drain();
      write_csr(REG_BIT_DEPTH, 48'd31);
      write_csr(REG_GAIN, 48'd0);
      write_csr(REG_OFFSET, 48'h8000_0000_0000);
      send_request(16'd5, 24'd256, 18'd4);
      drain();
      write_csr(REG_OFFSET, 48'h0000_0000_8000);
      send_request(16'd5, 24'd256, 18'd4);
      drain();
      write_csr(REG_BIT_DEPTH, 48'd0);
      write_csr(REG_GAIN, 48'h1_0000);
      write_csr(REG_OFFSET, 48'h0000_0080_0000);
      write_csr(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
      send_request(16'd128, 24'd32768, 18'd5);
      send_request(16'd200, 24'd32768, 18'd5);
      // random phases across idle/stall mixes and settings
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 22 : 59) : 0;
         recv_stall_pct = (ph % 4 == 2) ? 59 : ((ph % 4 == 3) ? 22 : 0);
         write_csr(REG_BIT_DEPTH, 48'($urandom_range(20)));
         write_csr(REG_GAIN, 48'($urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 20)));
         write_csr(REG_OFFSET, $urandom_range(1) ? 48'({$urandom, $urandom}) :
                   48'($signed(32'($urandom_range(1 << 26))) - (1 << 25)));
         random_phase(145);
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #30ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule
